// ===== hw/rtl/bsc_pkg.sv =====
// Shared types, constants and calibration decode for the barometric compensation core.
`timescale 1ns / 1ps
package bsc_pkg;

	localparam int PRESSURE_FRAC_BITS = 6;
	localparam int PSHIFT = 24 - PRESSURE_FRAC_BITS;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int LAT = 12;

	localparam logic [1:0] REG_CAL_LOW  = 2'd0;
	localparam logic [1:0] REG_CAL_MID  = 2'd1;
	localparam logic [1:0] REG_CAL_HIGH = 2'd2;

	typedef struct packed {
		logic [23:0] raw_pressure;
		logic [23:0] raw_temperature;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] temperature_centi;
		logic [23:0]        pressure_scaled;
		logic               out_of_range;
	} out_word_t;

	typedef struct packed {
		logic [15:0]        t1;
		logic [15:0]        t2;
		logic signed [7:0]  t3;
		logic signed [15:0] p1;
		logic signed [15:0] p2;
		logic signed [7:0]  p3;
		logic signed [7:0]  p4;
		logic [15:0]        p5;
		logic [15:0]        p6;
		logic signed [7:0]  p7;
		logic signed [7:0]  p8;
		logic signed [15:0] p9;
		logic signed [7:0]  p10;
		logic signed [7:0]  p11;
	} coef_t;

	function automatic coef_t coef_decode(input logic [63:0] lo, input logic [63:0] mid,
		input logic [39:0] hi);
		logic [167:0] c;
		coef_t r;
		c = {hi, mid, lo};
		r.t1  = c[15:0];
		r.t2  = c[31:16];
		r.t3  = c[39:32];
		r.p1  = c[55:40];
		r.p2  = c[71:56];
		r.p3  = c[79:72];
		r.p4  = c[87:80];
		r.p5  = c[103:88];
		r.p6  = c[119:104];
		r.p7  = c[127:120];
		r.p8  = c[135:128];
		r.p9  = c[151:136];
		r.p10 = c[159:152];
		r.p11 = c[167:160];
		return r;
	endfunction

endpackage

// ===== hw/rtl/barometric_sensor_compensation_core.sv =====
// Top level: calibration registers, input queue and compensation pipeline.
`timescale 1ns / 1ps
// Takes one raw pressure/temperature word per cycle and returns one compensated word per
// input, in order. A word passes a 4-entry input queue and then a 12-stage pipeline; with no
// output stall the sustained rate is one word per clock. An out stall while out_valid is
// high freezes the whole pipeline, and the queue absorbs up to 4 more words before in_stall
// rises. The user writes calibration registers only while idle; no logic here checks it.
module barometric_sensor_compensation_core import bsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] cal_lo_q, cal_mid_q;
	logic [39:0] cal_hi_q;
	coef_t       cf;
	logic        q_valid, pop_req;
	in_word_t    q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_lo_q  <= '0;
			cal_mid_q <= '0;
			cal_hi_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAL_LOW:  cal_lo_q  <= cfg_data;
				REG_CAL_MID:  cal_mid_q <= cfg_data;
				REG_CAL_HIGH: cal_hi_q  <= cfg_data[39:0];
				default: ;
			endcase
		end
	end

	assign cf = coef_decode(cal_lo_q, cal_mid_q, cal_hi_q);

	bsc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.pop_req(pop_req), .q_valid(q_valid), .q_data(q_data)
	);

	bsc_back u_back (
		.clk(clk), .arst_n(arst_n), .cf(cf),
		.q_valid(q_valid), .q_data(q_data), .pop_req(pop_req),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule

// ===== hw/rtl/bsc_front.sv =====
// Input side: takes measurement words into a short queue ahead of the datapath.
`timescale 1ns / 1ps
module bsc_front import bsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_word_t in_data,
	input  logic     pop_req,
	output logic     q_valid,
	output in_word_t q_data
);

	in_word_t       mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q, rptr_q;
	logic [QAW:0]   count_q;
	logic           push, pop;

	assign in_stall = (count_q == (QAW+1)'(QDEPTH));
	assign q_valid  = (count_q != '0);
	assign q_data   = mem_q[rptr_q];
	assign push     = in_valid && !in_stall;
	assign pop      = pop_req && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH)) else $error("queue count overflow");
	a_pop_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 1'b1)) else $error("queue pop lost");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q[QAW-1:0] == wptr_q - rptr_q)) else $error("queue pointers disagree");

endmodule

// ===== hw/rtl/bsc_back.sv =====
// Datapath: pipelined temperature and pressure polynomial evaluation with output register.
`timescale 1ns / 1ps
module bsc_back import bsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  coef_t     cf,
	input  logic      q_valid,
	input  in_word_t  q_data,
	output logic      pop_req,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data
);

	logic [LAT-1:0] vld_q;
	logic           en;

	assign en       = !(vld_q[LAT-1] && out_stall);
	assign pop_req  = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], q_valid};
		end
	end

	// stage registers
	logic signed [24:0] d_s1;
	logic [23:0] up_s1, up_s2, up_s3, up_s4, up_s5, up_s6, up_s7, up_s8, up_s9;
	logic signed [41:0] dt2_s2;
	logic signed [49:0] dd_s2;
	logic [47:0] upup_s2;
	logic signed [35:0] t_s3;
	logic signed [56:0] bu_s3;
	logic signed [42:0] t100_s4;
	logic signed [31:0] tq_s4, tq_s5;
	logic signed [36:0] b_s4, b_s5, b_s6, b_s7;
	logic oor_s4, oor_s5, oor_s6, oor_s7, oor_s8, oor_s9, oor_s10, oor_s11;
	logic signed [15:0] centi_s5, centi_s6, centi_s7, centi_s8, centi_s9, centi_s10, centi_s11;
	logic signed [63:0] tt_s5;
	logic signed [48:0] pt2_s5, pt2_s6, pt2_s7, pt2_s8;
	logic signed [48:0] p6tq_s5, p6tq_s6, p6tq_s7, p6tq_s8;
	logic signed [39:0] p10tq_s5;
	logic signed [39:0] tsq_s6;
	logic signed [63:0] tcup_s6;
	logic signed [32:0] m1_s6;
	logic signed [39:0] tcu_s7;
	logic signed [47:0] p3tsq_s7, p3tsq_s8, p7tsq_s7, p7tsq_s8;
	logic signed [57:0] upm1_s7;
	logic signed [58:0] uph_s8;
	logic signed [61:0] ub_s8;
	logic signed [47:0] p4tcu_s8, p8tcu_s8;
	logic signed [39:0] k_s9;
	logic signed [49:0] suma_s9, suma_s10;
	logic signed [64:0] upk_s10;
	logic signed [51:0] acc_s11;
	out_word_t out_s12;

	// combinational helpers
	logic signed [57:0] ddt3;
	logic signed [59:0] tsum;
	logic signed [42:0] t100r;
	logic signed [18:0] c19;
	logic signed [16:0] p1m, p2m;
	logic signed [40:0] m1sum;
	logic signed [33:0] h;
	logic signed [51:0] pfull;

	always_comb begin
		ddt3  = dd_s2 * cf.t3;
		tsum  = (60'(dt2_s2) <<< 18) + 60'(ddt3);
		t100r = t100_s4 + (t100_s4[42] ? 43'sd16777215 : 43'sd0);
		c19   = t100r[42:24];
		p1m   = 17'(cf.p1) - 17'sd16384;
		p2m   = 17'(cf.p2) - 17'sd16384;
		m1sum = (41'(cf.p9) <<< 24) + 41'(p10tq_s5);
		h     = upm1_s7[57:24];
		pfull = acc_s11 >>> PSHIFT;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// S1: offset of raw temperature
			d_s1  <= $signed({1'b0, q_data.raw_temperature}) - $signed({1'b0, cf.t1, 8'd0});
			up_s1 <= q_data.raw_pressure;
			// S2
			dt2_s2  <= d_s1 * $signed({1'b0, cf.t2});
			dd_s2   <= 50'(d_s1) * 50'(d_s1);
			upup_s2 <= up_s1 * up_s1;
			up_s2   <= up_s1;
			// S3: temperature Q.24
			t_s3  <= tsum[59:24];
			bu_s3 <= $signed({1'b0, upup_s2}) * cf.p11;
			up_s3 <= up_s2;
			// S4: scale for centi degrees, clamp to Q8.24
			t100_s4 <= 43'(t_s3) * 43'sd100;
			if (t_s3[35:31] != {5{t_s3[31]}}) begin
				tq_s4  <= t_s3[35] ? 32'sh80000000 : 32'sh7fffffff;
				oor_s4 <= 1'b1;
			end else begin
				tq_s4  <= t_s3[31:0];
				oor_s4 <= 1'b0;
			end
			b_s4  <= bu_s3[56:20];
			up_s4 <= up_s3;
			// S5: centi saturation, temperature products
			if (c19 > 19'sd32767) begin
				centi_s5 <= 16'sh7fff;
				oor_s5   <= 1'b1;
			end else if (c19 < -19'sd32768) begin
				centi_s5 <= 16'sh8000;
				oor_s5   <= 1'b1;
			end else begin
				centi_s5 <= c19[15:0];
				oor_s5   <= oor_s4;
			end
			tt_s5    <= 64'(tq_s4) * 64'(tq_s4);
			pt2_s5   <= p2m * tq_s4;
			p6tq_s5  <= $signed({1'b0, cf.p6}) * tq_s4;
			p10tq_s5 <= cf.p10 * tq_s4;
			tq_s5    <= tq_s4;
			b_s5     <= b_s4;
			up_s5    <= up_s4;
			// S6
			tsq_s6   <= tt_s5[63:24];
			tcup_s6  <= $signed(tt_s5[63:24]) * $signed(tq_s5[31:8]);
			m1_s6    <= m1sum[40:8];
			pt2_s6   <= pt2_s5;
			p6tq_s6  <= p6tq_s5;
			b_s6     <= b_s5;
			up_s6    <= up_s5;
			centi_s6 <= centi_s5;
			oor_s6   <= oor_s5;
			// S7
			tcu_s7   <= tcup_s6[63:24];
			p3tsq_s7 <= cf.p3 * tsq_s6;
			p7tsq_s7 <= cf.p7 * tsq_s6;
			upm1_s7  <= $signed({1'b0, up_s6}) * m1_s6;
			pt2_s7   <= pt2_s6;
			p6tq_s7  <= p6tq_s6;
			b_s7     <= b_s6;
			up_s7    <= up_s6;
			centi_s7 <= centi_s6;
			oor_s7   <= oor_s6;
			// S8
			uph_s8   <= $signed({1'b0, up_s7}) * h;
			ub_s8    <= b_s7 * $signed({1'b0, up_s7});
			p4tcu_s8 <= cf.p4 * tcu_s7;
			p8tcu_s8 <= cf.p8 * tcu_s7;
			pt2_s8   <= pt2_s7;
			p3tsq_s8 <= p3tsq_s7;
			p7tsq_s8 <= p7tsq_s7;
			p6tq_s8  <= p6tq_s7;
			up_s8    <= up_s7;
			centi_s8 <= centi_s7;
			oor_s8   <= oor_s7;
			// S9: linear coefficient K and the other pressure terms
			k_s9 <= (40'(p1m) <<< 20) + 40'(pt2_s8 >>> 13) + 40'(p3tsq_s8 >>> 16)
				+ 40'(p4tcu_s8 >>> 13);
			suma_s9 <= (50'($signed({1'b0, cf.p5})) <<< 27) + 50'(p6tq_s8 >>> 6)
				+ 50'(p7tsq_s8 >>> 8) + 50'(p8tcu_s8 >>> 7) + 50'(uph_s8 >>> 16)
				+ 50'(ub_s8 >>> 21);
			up_s9    <= up_s8;
			centi_s9 <= centi_s8;
			oor_s9   <= oor_s8;
			// S10
			upk_s10   <= 65'($signed({1'b0, up_s9})) * 65'(k_s9);
			suma_s10  <= suma_s9;
			centi_s10 <= centi_s9;
			oor_s10   <= oor_s9;
			// S11
			acc_s11   <= 52'(suma_s10) + 52'(upk_s10 >>> 16);
			centi_s11 <= centi_s10;
			oor_s11   <= oor_s10;
			// S12: pressure clamp, output word
			out_s12.temperature_centi <= centi_s11;
			if (pfull[51]) begin
				out_s12.pressure_scaled <= '0;
				out_s12.out_of_range    <= 1'b1;
			end else if (pfull[51:24] != '0) begin
				out_s12.pressure_scaled <= '1;
				out_s12.out_of_range    <= 1'b1;
			end else begin
				out_s12.pressure_scaled <= pfull[23:0];
				out_s12.out_of_range    <= oor_s11;
			end
		end
	end

	assign out_data = out_s12;

	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[LAT-1] && out_stall) |=> (vld_q == $past(vld_q))) else $error("pipe moved on stall");
	a_no_pop_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[LAT-1] && out_stall) |-> !pop_req) else $error("pop while stalled");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(en && q_valid) |=> vld_q[0]) else $error("word dropped at entry");

endmodule
